// File: rtl/wsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_pkg
// Shared types and constants for the WebSocket frame unmasker: parser phase
// encoding, result kind codes and header field constants.
// ----------------------------------------------------------------------------
package wsu_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_KEY     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_HALT    = 3'd4
    } phase_t;

    // Result kind codes
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Header fields
    localparam logic [3:0] OPCODE_CLOSE = 4'd8;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam int         KEY_BYTES    = 4;

    typedef logic [7:0] byte_t;

endpackage : wsu_pkg

// File: rtl/websocket_frame_unmasker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_core
// Receive-side parser for masked client-to-server WebSocket frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready/s_rx_byte) carries raw link bytes, one per
//   beat. Output channel (m_valid/m_ready/m_*) carries results: an unmasked
//   payload byte (with m_frame_last on the final byte of its frame), a close
//   notice after the fourth key byte of a close frame, or a protocol error
//   (extended length code or clear mask bit). Header and key bytes and
//   zero-length frames produce no beat.
//   Results are registered: a result appears on m_* in the cycle after the
//   input beat that caused it. Throughput: one byte per cycle, set by the
//   single output register; s_ready stays high while that register is empty
//   or is being drained in the same cycle.
//   Receiver stall: while m_valid is high and m_ready low, s_ready drops and
//   the parser state holds.
//   Reset (aresetn low, synchronous): parser waits for the first header byte
//   and the output register is empty. After a close or error result the block
//   keeps accepting and discarding bytes until the next reset.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_core (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_data_byte,
    output logic       m_frame_last
);

    // Parser state
    wsu_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      opcode_reg, opcode_next;
    wsu_pkg::byte_t  key_reg [wsu_pkg::KEY_BYTES];
    logic [1:0]      key_cnt_reg, key_cnt_next;
    logic [6:0]      remain_reg, remain_next;
    logic [1:0]      mask_pos_reg, mask_pos_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic [1:0] kind_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    // Result for the current beat
    logic       res_valid;
    logic [1:0] res_kind;
    logic [7:0] res_data;
    logic       res_last;

    logic       s_accept;
    logic [6:0] hdr_len;
    logic       hdr_bad;
    logic       pay_last;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign hdr_len  = s_rx_byte[6:0];
    assign hdr_bad  = (hdr_len == wsu_pkg::LEN_EXT16) || (hdr_len == wsu_pkg::LEN_EXT64)
                      || !s_rx_byte[7];
    assign pay_last = (remain_reg <= 7'd1);

    // Next-state logic
    always_comb begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        key_cnt_next  = key_cnt_reg;
        remain_next   = remain_reg;
        mask_pos_next = mask_pos_reg;
        if (s_accept) begin
            unique case (phase_reg)
                wsu_pkg::PH_HDR0: begin
                    opcode_next = s_rx_byte[3:0];
                    phase_next  = wsu_pkg::PH_HDR1;
                end
                wsu_pkg::PH_HDR1: begin
                    if (hdr_bad) begin
                        phase_next = wsu_pkg::PH_HALT;
                    end else begin
                        remain_next  = hdr_len;
                        key_cnt_next = 2'd0;
                        phase_next   = wsu_pkg::PH_KEY;
                    end
                end
                wsu_pkg::PH_KEY: begin
                    key_cnt_next = key_cnt_reg + 2'd1;
                    if (key_cnt_reg == 2'd3) begin
                        mask_pos_next = 2'd0;
                        if (opcode_reg == wsu_pkg::OPCODE_CLOSE) begin
                            phase_next = wsu_pkg::PH_HALT;
                        end else if (remain_reg == 7'd0) begin
                            phase_next = wsu_pkg::PH_HDR0;
                        end else begin
                            phase_next = wsu_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsu_pkg::PH_PAYLOAD: begin
                    mask_pos_next = mask_pos_reg + 2'd1;
                    remain_next   = remain_reg - 7'd1;
                    if (pay_last) begin
                        phase_next = wsu_pkg::PH_HDR0;
                    end
                end
                default: begin
                    phase_next = wsu_pkg::PH_HALT;
                end
            endcase
        end
    end

    // Result logic
    always_comb begin
        res_valid = 1'b0;
        res_kind  = wsu_pkg::KIND_DATA;
        res_data  = 8'd0;
        res_last  = 1'b0;
        unique case (phase_reg)
            wsu_pkg::PH_HDR1: begin
                if (hdr_bad) begin
                    res_valid = 1'b1;
                    res_kind  = wsu_pkg::KIND_ERROR;
                end
            end
            wsu_pkg::PH_KEY: begin
                if ((key_cnt_reg == 2'd3) && (opcode_reg == wsu_pkg::OPCODE_CLOSE)) begin
                    res_valid = 1'b1;
                    res_kind  = wsu_pkg::KIND_CLOSE;
                end
            end
            wsu_pkg::PH_PAYLOAD: begin
                res_valid = 1'b1;
                res_data  = s_rx_byte ^ key_reg[mask_pos_reg];
                res_last  = pay_last;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Output register valid: load on accept, clear when drained
    always_comb begin
        if (s_accept) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= wsu_pkg::PH_HDR0;
            opcode_reg   <= 4'd0;
            key_cnt_reg  <= 2'd0;
            remain_reg   <= 7'd0;
            mask_pos_reg <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            key_cnt_reg  <= key_cnt_next;
            remain_reg   <= remain_next;
            mask_pos_reg <= mask_pos_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Key capture and result payload
    always_ff @(posedge aclk) begin
        if (s_accept && (phase_reg == wsu_pkg::PH_KEY)) begin
            key_reg[key_cnt_reg] <= s_rx_byte;
        end
        if (s_accept) begin
            kind_reg <= res_kind;
            data_reg <= res_data;
            last_reg <= res_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_kind   = kind_reg;
    assign m_data_byte  = data_reg;
    assign m_frame_last = last_reg;

    // Assertions
    a_halt_after_notice: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && res_valid && (res_kind != wsu_pkg::KIND_DATA))
        |=> (phase_reg == wsu_pkg::PH_HALT))
        else $error("close/error result not followed by halt");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wsu_pkg::PH_HALT) |=> (phase_reg == wsu_pkg::PH_HALT))
        else $error("parser left halt without reset");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wsu_pkg::PH_HALT) |-> !res_valid)
        else $error("result produced while halted");

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wsu_pkg::PH_PAYLOAD) |-> (remain_reg != 7'd0))
        else $error("payload phase with no bytes remaining");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && res_valid && res_last) |=> (phase_reg == wsu_pkg::PH_HDR0))
        else $error("last payload byte did not return to header");

    a_notice_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind != wsu_pkg::KIND_DATA))
        |-> ((m_data_byte == 8'd0) && !m_frame_last))
        else $error("close/error result carries data");

endmodule : websocket_frame_unmasker_core
